### rtl/core/gradient_line_rasterizer_top_defines.svh
// Assertion macros for the gradient line rasterizer.
// Included by the top level; the checks vanish when SYNTHESIS is defined.
`ifndef GRADIENT_LINE_RASTERIZER_TOP_DEFINES_SVH
`define GRADIENT_LINE_RASTERIZER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define GLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/glr_pkg.sv
// Shared constants and types of the gradient line rasterizer.
// No dependencies; used by gradient_line_rasterizer_top.
package glr_pkg;

    localparam int COORD_BITS = 12;
    localparam int CHAN_BITS  = 8;
    localparam int NUM_CHAN   = 3;
    localparam int COLOR_BITS = NUM_CHAN * CHAN_BITS;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int PROD_BITS  = COORD_BITS + CHAN_BITS;
    localparam int DIFF_BITS  = CHAN_BITS + 1;
    localparam int CHAN_IDX_BITS = $clog2(NUM_CHAN);
    localparam int BIT_CNT_BITS  = $clog2(CHAN_BITS);

    localparam int IN_RAW_BITS   = 4 * COORD_BITS + 2 * COLOR_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    // Input operation codes carried on tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_PUT  = 4'b1000
    } state_t;

endpackage

### rtl/core/gradient_line_rasterizer_top.sv
// Gradient line rasterizer: Bresenham stepping with exact integer color interpolation.
// Depends on glr_pkg and on gradient_line_rasterizer_top_defines.svh for assertions.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser = op, tdata = endpoints, colors
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata = x, y, color, tlast = last pixel
//
// A load transaction is accepted and its first pixel is written to the output register in the
// next cycle, unless a result still waits on m_axis_tready. A step transaction that produces
// a pixel runs the accept, then for each of the three channels a multiply and a pass of the
// shared restoring divider, one quotient bit per step, then the write of the output register.
// A step past the end of the line yields no pixel. Reset is asynchronous and needs no sweep.
// A result waiting on m_axis_tready stalls only the final write of the next result.

`include "gradient_line_rasterizer_top_defines.svh"

module gradient_line_rasterizer_top
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // From bit 0: start_x, start_y, end_x, end_y, start_color, end_color.
    input  logic [glr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // op: load a new line or advance one pixel.
    input  logic                               s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // From bit 0: pixel_x, pixel_y, pixel_color, then zero fill.
    output logic [glr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // last_pixel: this pixel is the end point of the line.
    output logic                               m_axis_tlast
);

    localparam int CB = glr_pkg::COORD_BITS;
    localparam int EB = glr_pkg::ERR_BITS;
    localparam int EW = glr_pkg::ERR_BITS + 2;
    localparam int CH = glr_pkg::CHAN_BITS;
    localparam int PB = glr_pkg::PROD_BITS;

    // Control state.
    glr_pkg::state_t state_reg, state_next;
    logic [CB-1:0]   step_index_reg, step_index_next;
    logic [CB-1:0]   total_steps_reg, total_steps_next;
    logic            out_valid_reg, out_valid_next;

    // Line state.
    logic [CB-1:0]        cur_x_reg;
    logic [CB-1:0]        cur_y_reg;
    logic [CB-1:0]        abs_dx_reg;
    logic [CB-1:0]        abs_dy_reg;
    logic                 step_x_neg_reg;
    logic                 step_y_neg_reg;
    logic signed [EB-1:0] err_reg;
    logic [glr_pkg::COLOR_BITS-1:0] base_color_reg;
    logic signed [glr_pkg::DIFF_BITS-1:0] diff_reg [glr_pkg::NUM_CHAN];

    // Shared multiply and divide unit.
    logic [glr_pkg::CHAN_IDX_BITS-1:0] chan_reg;
    logic [PB-1:0]                     rem_reg;
    logic [PB-1:0]                     div_reg;
    logic [CH-1:0]                     quot_reg;
    logic [glr_pkg::BIT_CNT_BITS-1:0]  bit_cnt_reg;
    logic                              neg_reg;

    // Pending result and output register.
    logic [glr_pkg::COLOR_BITS-1:0] color_reg;
    logic                           last_reg;
    logic [CB-1:0]                  out_x_reg;
    logic [CB-1:0]                  out_y_reg;
    logic [glr_pkg::COLOR_BITS-1:0] out_color_reg;
    logic                           out_last_reg;

    // Handshake and sequencing terms.
    logic accept;
    logic is_load;
    logic line_done;
    logic out_free;
    logic last_bit;
    logic last_chan;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_load   = (s_axis_tuser == glr_pkg::OP_LOAD);
    assign line_done = (step_index_reg >= total_steps_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_bit  = (bit_cnt_reg == '0);
    assign last_chan = (chan_reg == glr_pkg::CHAN_IDX_BITS'(glr_pkg::NUM_CHAN - 1));

    // Unpacked load fields.
    logic signed [CB-1:0] ld_x0, ld_y0, ld_x1, ld_y1;
    logic [glr_pkg::COLOR_BITS-1:0] ld_c0, ld_c1;

    assign ld_x0 = s_axis_tdata[0*CB +: CB];
    assign ld_y0 = s_axis_tdata[1*CB +: CB];
    assign ld_x1 = s_axis_tdata[2*CB +: CB];
    assign ld_y1 = s_axis_tdata[3*CB +: CB];
    assign ld_c0 = s_axis_tdata[4*CB +: glr_pkg::COLOR_BITS];
    assign ld_c1 = s_axis_tdata[4*CB + glr_pkg::COLOR_BITS +: glr_pkg::COLOR_BITS];

    // Line setup: deltas, directions, initial error and step count.
    logic signed [CB:0]   ld_dx, ld_dy, ld_adx, ld_ady;
    logic [CB-1:0]        ld_abs_dx, ld_abs_dy, ld_total;
    logic                 ld_x_neg, ld_y_neg;
    logic signed [EB-1:0] ld_err;
    logic signed [glr_pkg::DIFF_BITS-1:0] ld_diff [glr_pkg::NUM_CHAN];

    always_comb
    begin
        ld_dx     = (CB+1)'(ld_x1) - (CB+1)'(ld_x0);
        ld_dy     = (CB+1)'(ld_y1) - (CB+1)'(ld_y0);
        ld_adx    = ld_dx[CB] ? -ld_dx : ld_dx;
        ld_ady    = ld_dy[CB] ? -ld_dy : ld_dy;
        ld_abs_dx = ld_adx[CB-1:0];
        ld_abs_dy = ld_ady[CB-1:0];
        // The direction is negative unless the end lies strictly beyond the start.
        ld_x_neg  = ld_dx[CB] || (ld_dx == '0);
        ld_y_neg  = ld_dy[CB] || (ld_dy == '0);
        ld_err    = $signed({{(EB-CB){1'b0}}, ld_abs_dx})
                  - $signed({{(EB-CB){1'b0}}, ld_abs_dy});
        ld_total  = (ld_abs_dx > ld_abs_dy) ? ld_abs_dx : ld_abs_dy;
        for (int k = 0; k < glr_pkg::NUM_CHAN; k++)
        begin
            ld_diff[k] = $signed({1'b0, ld_c1[(glr_pkg::NUM_CHAN-1-k)*CH +: CH]})
                       - $signed({1'b0, ld_c0[(glr_pkg::NUM_CHAN-1-k)*CH +: CH]});
        end
    end

    // One Bresenham step. The second test sees the error already updated by the first.
    logic signed [EW-1:0] st_err, st_dx, st_dy, st_err_a, st_err_b;
    logic                 st_move_x, st_move_y;
    logic [CB-1:0]        st_index_inc;

    always_comb
    begin
        st_err    = EW'(err_reg);
        st_dx     = $signed({{(EW-CB){1'b0}}, abs_dx_reg});
        st_dy     = $signed({{(EW-CB){1'b0}}, abs_dy_reg});
        st_move_x = (st_err <<< 1) > -st_dy;
        st_err_a  = st_move_x ? (st_err - st_dy) : st_err;
        st_move_y = (st_err_a <<< 1) < st_dx;
        st_err_b  = st_move_y ? (st_err_a + st_dx) : st_err_a;
        st_index_inc = step_index_reg + 1'b1;
    end

    // Shared unit: magnitude product, then one restoring divide step per cycle.
    logic signed [glr_pkg::DIFF_BITS-1:0] cur_diff;
    logic signed [glr_pkg::DIFF_BITS-1:0] neg_diff;
    logic [CH-1:0] mag_diff;
    logic [PB-1:0] mul_out;
    logic          div_ge;
    logic [CH-1:0] quot_full;
    logic [CH-1:0] base_byte;
    logic [CH-1:0] chan_result;

    always_comb
    begin
        cur_diff    = diff_reg[chan_reg];
        neg_diff    = -cur_diff;
        mag_diff    = cur_diff[glr_pkg::DIFF_BITS-1] ? neg_diff[CH-1:0] : cur_diff[CH-1:0];
        mul_out     = mag_diff * step_index_reg;
        div_ge      = (rem_reg >= div_reg);
        quot_full   = {quot_reg[CH-2:0], div_ge};
        base_byte   = base_color_reg[(glr_pkg::NUM_CHAN-1-chan_reg)*CH +: CH];
        // The quotient never exceeds the channel difference, so the byte cannot wrap.
        chan_result = neg_reg ? (base_byte - quot_full) : (base_byte + quot_full);
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        step_index_next  = step_index_reg;
        total_steps_next = total_steps_reg;
        unique case (state_reg)
            glr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        state_next       = glr_pkg::ST_PUT;
                        step_index_next  = '0;
                        total_steps_next = ld_total;
                    end
                    else if (!line_done)
                    begin
                        state_next      = glr_pkg::ST_MUL;
                        step_index_next = st_index_inc;
                    end
                end
            end
            glr_pkg::ST_MUL:
            begin
                state_next = glr_pkg::ST_DIV;
            end
            glr_pkg::ST_DIV:
            begin
                if (last_bit)
                begin
                    state_next = last_chan ? glr_pkg::ST_PUT : glr_pkg::ST_MUL;
                end
            end
            glr_pkg::ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = glr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = glr_pkg::ST_IDLE;
            end
        endcase

        if ((state_reg == glr_pkg::ST_PUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= glr_pkg::ST_IDLE;
            step_index_reg  <= '0;
            total_steps_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_index_reg  <= step_index_next;
            total_steps_reg <= total_steps_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == glr_pkg::ST_IDLE) && accept && is_load)
        begin
            cur_x_reg      <= ld_x0;
            cur_y_reg      <= ld_y0;
            abs_dx_reg     <= ld_abs_dx;
            abs_dy_reg     <= ld_abs_dy;
            step_x_neg_reg <= ld_x_neg;
            step_y_neg_reg <= ld_y_neg;
            err_reg        <= ld_err;
            base_color_reg <= ld_c0;
            for (int k = 0; k < glr_pkg::NUM_CHAN; k++)
            begin
                diff_reg[k] <= ld_diff[k];
            end
            color_reg      <= ld_c0;
            last_reg       <= (ld_total == '0);
        end
        else if ((state_reg == glr_pkg::ST_IDLE) && accept && !line_done)
        begin
            if (st_move_x)
            begin
                cur_x_reg <= step_x_neg_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
            end
            if (st_move_y)
            begin
                cur_y_reg <= step_y_neg_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
            end
            err_reg  <= st_err_b[EB-1:0];
            chan_reg <= '0;
            last_reg <= (st_index_inc == total_steps_reg);
        end

        if (state_reg == glr_pkg::ST_MUL)
        begin
            rem_reg     <= mul_out;
            neg_reg     <= cur_diff[glr_pkg::DIFF_BITS-1];
            div_reg     <= PB'({total_steps_reg, {(CH-1){1'b0}}});
            quot_reg    <= '0;
            bit_cnt_reg <= glr_pkg::BIT_CNT_BITS'(CH - 1);
        end

        if (state_reg == glr_pkg::ST_DIV)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            div_reg     <= div_reg >> 1;
            quot_reg    <= quot_full;
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            if (last_bit)
            begin
                color_reg[(glr_pkg::NUM_CHAN-1-chan_reg)*CH +: CH] <= chan_result;
                // Wrap back to the first channel so the index always names a real channel.
                chan_reg <= last_chan ? '0 : (chan_reg + 1'b1);
            end
        end

        if ((state_reg == glr_pkg::ST_PUT) && out_free)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign s_axis_tready = (state_reg == glr_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = glr_pkg::OUT_DATA_BITS'({out_color_reg, out_y_reg, out_x_reg});
    assign m_axis_tlast  = out_last_reg;

    // The step counter never runs past the end of the line.
    `GLR_ASSERT_IMP(a_step_bound, clk, rst_n, 1'b1,
                    step_index_reg <= total_steps_reg, "step index past line end")
    // Interpolation only runs on an active line after at least one step.
    `GLR_ASSERT_IMP(a_div_active, clk, rst_n,
                    state_reg == glr_pkg::ST_MUL || state_reg == glr_pkg::ST_DIV,
                    total_steps_reg != '0 && step_index_reg != '0, "divide with no active line")
    // A result written from the pending stage shows up as valid in the next cycle.
    `GLR_ASSERT_NEXT(a_put_lands, clk, rst_n, state_reg == glr_pkg::ST_PUT && out_free,
                     m_axis_tvalid, "written result not presented")

endmodule
